// File: rtl/onewire_temp_sensor_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL files.
`ifndef ONEWIRE_TEMP_SENSOR_SEQUENCER_DEFINES_SVH
`define ONEWIRE_TEMP_SENSOR_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define OWTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define OWTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OWTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OWTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/owts_pkg.sv
// Types and constants of the 1-Wire temperature sequencer.
package owts_pkg;

	localparam int READ_BITS_DEF = 16;

	// bus timing in microseconds; one tick is 5 us
	localparam int RESET_LOW_US = 500;
	localparam int INIT_SLOT_US = 570;
	localparam int W0_LOW_US = 60;
	localparam int W1_LOW_US = 10;
	localparam int W1_REST_US = 50;
	localparam int RD_LOW_US = 5;
	localparam int RD_SAMPLE_US = 5;
	localparam int RD_REST_US = 45;

	localparam int TICK_W = 18;
	localparam int TICK5_W = 21;
	localparam int WD_W = 24;
	localparam int PD_W = 9;
	localparam int BITS_W = 5;
	localparam int TEMP_W = 16;

	localparam logic [15:0] CMD_FIRST = 16'h44CC;
	localparam logic [15:0] CMD_SECOND = 16'hBECC;

	// sequence positions; the conversion step follows the read slots
	localparam int POS_INIT1 = 1;
	localparam int POS_CMD1 = 2;
	localparam int POS_WAIT = 18;
	localparam int POS_INIT2 = 19;
	localparam int POS_CMD2 = 20;
	localparam int POS_READ = 36;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_LOW = 2'd1;
	localparam logic [1:0] PH_MID = 2'd2;
	localparam logic [1:0] PH_REST = 2'd3;

	localparam logic [PD_W-1:0] PRESENCE_DELAY_RST = 9'd130;
	localparam logic [TICK_W-1:0] CONVERT_WAIT_RST = 18'd150000;
	localparam logic [WD_W-1:0] WATCHDOG_RST = 24'd400000;

	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		REG_PRESENCE_DELAY = 2'd0,
		REG_CONVERT_WAIT = 2'd1,
		REG_WATCHDOG = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PD_W-1:0] presence_delay_us;
		logic [TICK_W-1:0] convert_wait_ticks;
		logic [WD_W-1:0] watchdog_ticks;
	} cfg_t;

	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic failed;
		logic [11:0] temp_integer;
		logic [3:0] temp_fraction;
		logic temp_negative;
		logic presence_seen;
	} res_t;

endpackage

// File: rtl/owts_seq.sv
// Slot sequencer, watchdog and temperature store; one tick per accepted item.
`include "onewire_temp_sensor_sequencer_defines.svh"
module owts_seq #(
	parameter int READ_BITS = owts_pkg::READ_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic start_req,
	input logic line_level,
	input owts_pkg::cfg_t cfg,
	output owts_pkg::res_t res
);

	localparam int POS_CONV = owts_pkg::POS_READ + READ_BITS;
	localparam int STEP_W = $clog2(POS_CONV + 1);
	localparam logic [STEP_W-1:0] S_IDLE = '0;
	localparam logic [STEP_W-1:0] S_INIT1 = STEP_W'(owts_pkg::POS_INIT1);
	localparam logic [STEP_W-1:0] S_CMD1 = STEP_W'(owts_pkg::POS_CMD1);
	localparam logic [STEP_W-1:0] S_WAIT = STEP_W'(owts_pkg::POS_WAIT);
	localparam logic [STEP_W-1:0] S_INIT2 = STEP_W'(owts_pkg::POS_INIT2);
	localparam logic [STEP_W-1:0] S_CMD2 = STEP_W'(owts_pkg::POS_CMD2);
	localparam logic [STEP_W-1:0] S_READ = STEP_W'(owts_pkg::POS_READ);
	localparam logic [STEP_W-1:0] S_CONV = STEP_W'(POS_CONV);

	localparam int TW = owts_pkg::TICK_W;
	localparam int T5W = owts_pkg::TICK5_W;
	localparam int WW = owts_pkg::WD_W;
	localparam int BW = owts_pkg::BITS_W;
	localparam int MW = owts_pkg::TEMP_W;

	logic [STEP_W-1:0] step_q, step_n;
	logic [1:0] phase_q, phase_n;
	logic [TW-1:0] tick_q, tick_n;
	logic [BW-1:0] bits_q, bits_n;
	logic [MW-1:0] shift_q, shift_n;
	logic [WW-1:0] wd_cnt_q, wd_cnt_n;
	logic wd_run_q, wd_run_n;
	logic run_ok_q, run_ok_n;
	logic pres_q, pres_n;
	logic [MW-1:0] mag_q, mag_n;
	logic sign_q, sign_n;

	logic done, fail, adv, wr_bit, in_slot;
	logic [T5W-1:0] tick5;
	logic [9:0] init_rest_us;
	logic [STEP_W-1:0] off;

	assign init_rest_us = 10'(owts_pkg::INIT_SLOT_US) - {1'b0, cfg.presence_delay_us};

	always_comb begin
		step_n = step_q;
		phase_n = phase_q;
		tick_n = tick_q;
		bits_n = bits_q;
		shift_n = shift_q;
		wd_cnt_n = wd_cnt_q;
		wd_run_n = wd_run_q;
		run_ok_n = run_ok_q;
		pres_n = pres_q;
		mag_n = mag_q;
		sign_n = sign_q;
		done = 1'b0;
		fail = 1'b0;
		adv = 1'b0;
		wr_bit = 1'b0;
		tick5 = '0;
		off = '0;

		if (start_req) begin
			step_n = S_INIT1;
			phase_n = owts_pkg::PH_START;
			tick_n = '0;
			bits_n = '0;
			shift_n = '0;
			wd_run_n = 1'b1;
			wd_cnt_n = '0;
			run_ok_n = 1'b0;
		end

		if (step_n != S_IDLE) begin
			if (tick_n != '1)
				tick_n = tick_n + 1'b1;
			tick5 = ({3'b000, tick_n} << 2) + {3'b000, tick_n};

			if (step_n == S_INIT1 || step_n == S_INIT2) begin
				case (phase_n)
					owts_pkg::PH_START: begin
						phase_n = owts_pkg::PH_LOW;
						tick_n = '0;
					end
					owts_pkg::PH_LOW: begin
						if (tick5 >= T5W'(owts_pkg::RESET_LOW_US)) begin
							phase_n = owts_pkg::PH_MID;
							tick_n = '0;
						end
					end
					owts_pkg::PH_MID: begin
						if (tick5 >= T5W'(cfg.presence_delay_us)) begin
							if (!line_level) begin
								pres_n = 1'b1;
								phase_n = owts_pkg::PH_REST;
								tick_n = '0;
							end else begin
								pres_n = 1'b0;
							end
						end
					end
					default: begin
						if (tick5 >= T5W'(init_rest_us)) begin
							phase_n = owts_pkg::PH_START;
							tick_n = '0;
							adv = 1'b1;
						end
					end
				endcase
			end else if ((step_n >= S_CMD1 && step_n < S_WAIT) ||
					(step_n >= S_CMD2 && step_n < S_READ)) begin
				if (step_n < S_WAIT) begin
					off = step_n - S_CMD1;
					wr_bit = owts_pkg::CMD_FIRST[off[3:0]];
				end else begin
					off = step_n - S_CMD2;
					wr_bit = owts_pkg::CMD_SECOND[off[3:0]];
				end
				if (phase_n == owts_pkg::PH_START) begin
					phase_n = owts_pkg::PH_LOW;
					tick_n = '0;
				end else if (!wr_bit) begin
					if (tick5 >= T5W'(owts_pkg::W0_LOW_US)) begin
						phase_n = owts_pkg::PH_START;
						tick_n = '0;
						adv = 1'b1;
					end
				end else if (phase_n == owts_pkg::PH_LOW) begin
					if (tick5 >= T5W'(owts_pkg::W1_LOW_US)) begin
						phase_n = owts_pkg::PH_MID;
						tick_n = '0;
					end
				end else if (tick5 >= T5W'(owts_pkg::W1_REST_US)) begin
					phase_n = owts_pkg::PH_START;
					tick_n = '0;
					adv = 1'b1;
				end
			end else if (step_n == S_WAIT) begin
				if (tick_n >= cfg.convert_wait_ticks) begin
					tick_n = '0;
					adv = 1'b1;
				end
			end else if (step_n >= S_READ && step_n < S_CONV) begin
				case (phase_n)
					owts_pkg::PH_START: begin
						phase_n = owts_pkg::PH_LOW;
						tick_n = '0;
					end
					owts_pkg::PH_LOW: begin
						if (tick5 >= T5W'(owts_pkg::RD_LOW_US)) begin
							phase_n = owts_pkg::PH_MID;
							tick_n = '0;
						end
					end
					owts_pkg::PH_MID: begin
						if (tick5 >= T5W'(owts_pkg::RD_SAMPLE_US)) begin
							// only the first 16 bits are kept; the count saturates
							if (bits_n < BW'(MW))
								shift_n[bits_n[3:0]] = line_level;
							if (bits_n != '1)
								bits_n = bits_n + 1'b1;
							phase_n = owts_pkg::PH_REST;
							tick_n = '0;
						end
					end
					default: begin
						if (tick5 >= T5W'(owts_pkg::RD_REST_US)) begin
							phase_n = owts_pkg::PH_START;
							tick_n = '0;
							adv = 1'b1;
						end
					end
				endcase
			end else if (step_n == S_CONV) begin
				sign_n = shift_n[MW-1];
				mag_n = sign_n ? (~shift_n + 1'b1) : shift_n;
				run_ok_n = 1'b1;
				step_n = S_IDLE;
				done = 1'b1;
			end else begin
				step_n = S_IDLE;
				phase_n = owts_pkg::PH_START;
				tick_n = '0;
			end
			if (adv)
				step_n = step_n + 1'b1;
		end

		if (wd_run_n) begin
			if (wd_cnt_n != '1)
				wd_cnt_n = wd_cnt_n + 1'b1;
			if (wd_cnt_n >= cfg.watchdog_ticks) begin
				if (!(run_ok_n && pres_n)) begin
					step_n = S_IDLE;
					phase_n = owts_pkg::PH_START;
					tick_n = '0;
					fail = 1'b1;
				end
				wd_cnt_n = '0;
				wd_run_n = 1'b0;
			end
		end
	end

	always_comb begin
		in_slot = step_n == S_INIT1 || step_n == S_INIT2 ||
			(step_n >= S_CMD1 && step_n < S_WAIT) ||
			(step_n >= S_CMD2 && step_n < S_CONV);
		res.drive_low = step_n != S_IDLE && phase_n == owts_pkg::PH_LOW && in_slot;
		res.busy_res = step_n != S_IDLE;
		res.done_res = done;
		res.failed = fail;
		res.temp_integer = mag_n[15:4];
		res.temp_fraction = mag_n[3:0];
		res.temp_negative = sign_n;
		res.presence_seen = pres_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			phase_q <= owts_pkg::PH_START;
			tick_q <= '0;
			bits_q <= '0;
			shift_q <= '0;
			wd_cnt_q <= '0;
			wd_run_q <= 1'b0;
			run_ok_q <= 1'b0;
			pres_q <= 1'b0;
			mag_q <= '0;
			sign_q <= 1'b0;
		end else if (accept) begin
			step_q <= step_n;
			phase_q <= phase_n;
			tick_q <= tick_n;
			bits_q <= bits_n;
			shift_q <= shift_n;
			wd_cnt_q <= wd_cnt_n;
			wd_run_q <= wd_run_n;
			run_ok_q <= run_ok_n;
			pres_q <= pres_n;
			mag_q <= mag_n;
			sign_q <= sign_n;
		end
	end

	`OWTS_ASSERT_IMP(a_done_idle, clk, arst_n, accept && res.done_res, !res.busy_res && !res.failed, "done without returning to idle or with failure")
	`OWTS_ASSERT_IMP(a_fail_idle, clk, arst_n, accept && res.failed, !res.busy_res, "abort left the sequence running")
	`OWTS_ASSERT_IMP(a_drive_busy, clk, arst_n, accept && res.drive_low, res.busy_res, "bus driven while idle")

endmodule

// File: rtl/owts_obuf.sv
// Two-entry output buffer: result register plus skid stage.
`include "onewire_temp_sensor_sequencer_defines.svh"
module owts_obuf (
	input logic clk,
	input logic arst_n,
	input logic push,
	input owts_pkg::res_t push_data,
	output logic full,
	output logic out_valid,
	input logic out_stall,
	output owts_pkg::res_t out_data
);

	logic main_valid_q, skid_valid_q;
	owts_pkg::res_t main_q, skid_q;
	logic pop;

	assign pop = main_valid_q && !out_stall;
	assign full = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!main_valid_q || pop)
				main_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_valid_q || pop)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	`OWTS_ASSERT_IMP(a_skid_behind_main, clk, arst_n, skid_valid_q, main_valid_q, "skid without main")
	`OWTS_ASSERT_NEXT(a_skid_drain, clk, arst_n, skid_valid_q && !out_stall, out_valid, "skid lost")
	`OWTS_ASSERT_NEXT(a_stall_hold, clk, arst_n, main_valid_q && out_stall, main_valid_q && $stable(main_q), "stalled result changed")

endmodule

// File: rtl/onewire_temp_sensor_sequencer.sv
// Top level of the 1-Wire temperature sensor read sequencer.
// Usage:
// - Input channel (in_valid/in_stall): one transfer per 5 us tick, carrying
//   start_req and the sampled bus level line_level.
// - Output channel (out_valid/out_stall): one result per input transfer with
//   drive_low for the open-drain pad, busy/done/failed flags, the stored
//   temperature magnitude as integer and sixteenths, its sign and presence.
// - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): presence
//   sample delay, conversion wait and watchdog length; cfg_ready is always
//   high; write only while no tick is in flight.
// Results are registered in the output buffer before they are presented.
// Throughput: one tick per cycle while in_stall is low; the sequencer step is a
//   single registered pass of counter compares, set by the state register loop.
// Reset: sequencer idle, flags and stored temperature cleared, registers at
//   130 us, 150000 ticks and 400000 ticks.
// Stall: a two-entry output buffer holds results; in_stall rises once both
//   entries are occupied, so up to two more transfers are taken after out_stall rises.
module onewire_temp_sensor_sequencer #(
	parameter int READ_BITS = owts_pkg::READ_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic start_req,
	input logic line_level,
	output logic out_valid,
	input logic out_stall,
	output logic drive_low,
	output logic busy_res,
	output logic done_res,
	output logic failed,
	output logic [11:0] temp_integer,
	output logic [3:0] temp_fraction,
	output logic temp_negative,
	output logic presence_seen,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [owts_pkg::CFG_DATA_W-1:0] cfg_data
);

	owts_pkg::cfg_t cfg_q;
	owts_pkg::res_t seq_res, out_res;
	logic accept, buf_full;

	assign cfg_ready = 1'b1;
	assign in_stall = buf_full;
	assign accept = in_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.presence_delay_us <= owts_pkg::PRESENCE_DELAY_RST;
			cfg_q.convert_wait_ticks <= owts_pkg::CONVERT_WAIT_RST;
			cfg_q.watchdog_ticks <= owts_pkg::WATCHDOG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (owts_pkg::cfg_reg_t'(cfg_index))
				owts_pkg::REG_PRESENCE_DELAY:
					cfg_q.presence_delay_us <= cfg_data[owts_pkg::PD_W-1:0];
				owts_pkg::REG_CONVERT_WAIT:
					cfg_q.convert_wait_ticks <= cfg_data[owts_pkg::TICK_W-1:0];
				owts_pkg::REG_WATCHDOG:
					cfg_q.watchdog_ticks <= cfg_data[owts_pkg::WD_W-1:0];
				default: ;
			endcase
		end
	end

	owts_seq #(
		.READ_BITS(READ_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.start_req(start_req),
		.line_level(line_level),
		.cfg(cfg_q),
		.res(seq_res)
	);

	owts_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_data(seq_res),
		.full(buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_res)
	);

	assign drive_low = out_res.drive_low;
	assign busy_res = out_res.busy_res;
	assign done_res = out_res.done_res;
	assign failed = out_res.failed;
	assign temp_integer = out_res.temp_integer;
	assign temp_fraction = out_res.temp_fraction;
	assign temp_negative = out_res.temp_negative;
	assign presence_seen = out_res.presence_seen;

endmodule
